// ----- rtl/tbl_pkg.sv -----
package tbl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TOKEN_BITS = 16;

  localparam int RATE_W    = 24;
  localparam int BURST_W   = 16;
  localparam int ELAP_W    = 32;
  localparam int WANT_W    = 16;
  localparam int LEFT_W    = 16;
  localparam int WAIT_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam int LEVEL_W   = TOKEN_BITS + FRAC_BITS;
  localparam int PROD_W    = ELAP_W + RATE_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int NEED_W    = WANT_W + FRAC_BITS;
  localparam int CMP_W     = (NEED_W > LEVEL_W) ? NEED_W : LEVEL_W;
  localparam int DIV_CNT_W = $clog2(NEED_W);

  localparam logic [63:0] TOKEN_MAX = (64'd1 << TOKEN_BITS) - 64'd1;

  localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(65536);
  localparam logic [BURST_W-1:0] BURST_RST = BURST_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_RATE = CFG_IDX_W'(0),
    REG_BURST     = CFG_IDX_W'(1)
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic update;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

  function automatic logic [LEVEL_W-1:0] full_level(input logic [BURST_W-1:0] burst);
    logic [63:0] tok;
    tok = (64'(burst) > TOKEN_MAX) ? TOKEN_MAX : 64'(burst);
    return LEVEL_W'(tok << FRAC_BITS);
  endfunction

endpackage

// ----- rtl/tbl_ctrl.sv -----
module tbl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  tbl_pkg::status_t status_i,
  output tbl_pkg::cmd_t    cmd_o
);
  import tbl_pkg::*;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = status_i.need_div ? ST_DIV : ST_OUT;
      ST_DIV:  if (cnt_q == DIV_CNT_W'(NEED_W - 1)) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_UPD: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DIV_CNT_W'(1);
      end
      ST_OUT: cmd_o.out_load = out_free;
      default: ;
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/tbl_datapath.sv -----
module tbl_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbl_pkg::cmd_t                 cmd_i,
  output tbl_pkg::status_t              status_o,
  input  logic [tbl_pkg::ELAP_W-1:0]    elapsed_ticks_i,
  input  logic [tbl_pkg::WANT_W-1:0]    tokens_wanted_i,
  input  logic                          refill_to_full_i,
  input  logic                          cfg_we_i,
  input  logic [tbl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tbl_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                          granted_o,
  output logic [tbl_pkg::LEFT_W-1:0]    tokens_left_o,
  output logic [tbl_pkg::WAIT_W-1:0]    wait_ticks_o,
  output logic                          never_available_o
);
  import tbl_pkg::*;

  logic [RATE_W-1:0]  rate_q;
  logic [BURST_W-1:0] burst_q;
  logic [LEVEL_W-1:0] level_q, level_d;

  logic [ELAP_W-1:0]  elapsed_q;
  logic [WANT_W-1:0]  wanted_q;
  logic               to_full_q;
  logic [PROD_W-1:0]  prod_q;
  logic               granted_q;
  logic               never_q;
  logic [NEED_W-1:0]  dvd_q;
  logic [RATE_W-1:0]  rem_q;

  logic [LEVEL_W-1:0] cap;
  logic [LEVEL_W-1:0] new_burst_cap;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] refilled;
  logic [NEED_W-1:0]  needed;
  logic               grant;
  logic [RATE_W:0]    rem_shift;
  logic               q_bit;

  assign cap           = full_level(burst_q);
  assign new_burst_cap = full_level(BURST_W'(cfg_data_i));
  assign sum           = SUM_W'(level_q) + SUM_W'(prod_q);

  always_comb begin
    if (to_full_q) begin
      refilled = cap;
    end else if (sum > SUM_W'(cap)) begin
      refilled = cap;
    end else begin
      refilled = LEVEL_W'(sum);
    end
  end

  assign needed = NEED_W'(wanted_q) << FRAC_BITS;
  assign grant  = CMP_W'(refilled) >= CMP_W'(needed);

  assign status_o.need_div = !grant && (rate_q != '0);

  assign rem_shift = {rem_q, dvd_q[NEED_W-1]};
  assign q_bit     = rem_shift >= (RATE_W + 1)'(rate_q);

  always_comb begin
    level_d = level_q;
    if (cfg_we_i && cfg_index_i == REG_BURST) begin
      if (level_q > new_burst_cap) level_d = new_burst_cap;
    end else if (cmd_i.update) begin
      if (grant) begin
        level_d = LEVEL_W'(CMP_W'(refilled) - CMP_W'(needed));
      end else begin
        level_d = refilled;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RST;
      burst_q <= BURST_RST;
      level_q <= full_level(BURST_RST);
    end else begin
      level_q <= level_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FILL_RATE: rate_q  <= RATE_W'(cfg_data_i);
          REG_BURST:     burst_q <= BURST_W'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      elapsed_q <= elapsed_ticks_i;
      wanted_q  <= tokens_wanted_i;
      to_full_q <= refill_to_full_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(elapsed_q) * PROD_W'(rate_q);
    end
    if (cmd_i.update) begin
      granted_q <= grant;
      never_q   <= !grant && (rate_q == '0);
      dvd_q     <= NEED_W'(CMP_W'(needed) - CMP_W'(refilled));
      rem_q     <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NEED_W-2:0], q_bit};
      rem_q <= q_bit ? RATE_W'(rem_shift - (RATE_W + 1)'(rate_q)) : RATE_W'(rem_shift);
    end
    if (cmd_i.out_load) begin
      granted_o         <= granted_q;
      never_available_o <= never_q;
      tokens_left_o     <= LEFT_W'(level_q >> FRAC_BITS);
      if (never_q) begin
        wait_ticks_o <= '1;
      end else if (granted_q) begin
        wait_ticks_o <= '0;
      end else begin
        wait_ticks_o <= WAIT_W'(dvd_q);
      end
    end
  end

endmodule

// ----- rtl/token_bucket_limiter_core.sv -----
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    elapsed_ticks, tokens_wanted, refill_to_full
// out       source     out_valid/out_stall  granted, tokens_left, wait_ticks, never_available
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A granted request, or one refused at zero rate, passes from accept through the
// multiply, update and output steps; other refusals also pass the bit-serial divider.
// Reset fills the bucket and loads the default rate and burst.
// A finished result waits in the output register; the next request is
// accepted meanwhile and stalls only at its own output step.
module token_bucket_limiter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tbl_pkg::ELAP_W-1:0]    elapsed_ticks_i,
  input  logic [tbl_pkg::WANT_W-1:0]    tokens_wanted_i,
  input  logic                          refill_to_full_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [tbl_pkg::LEFT_W-1:0]    tokens_left_o,
  output logic [tbl_pkg::WAIT_W-1:0]    wait_ticks_o,
  output logic                          never_available_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tbl_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import tbl_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tbl_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .elapsed_ticks_i   (elapsed_ticks_i),
    .tokens_wanted_i   (tokens_wanted_i),
    .refill_to_full_i  (refill_to_full_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .granted_o         (granted_o),
    .tokens_left_o     (tokens_left_o),
    .wait_ticks_o      (wait_ticks_o),
    .never_available_o (never_available_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tbl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = NEED_W + 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [ELAP_W-1:0] elapsed;
    logic [WANT_W-1:0] want;
    logic              to_full;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [LEFT_W-1:0] left;
    logic [WAIT_W-1:0] wait_cnt;
    logic              never;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ELAP_W-1:0]    elapsed_ticks = '0;
  logic [WANT_W-1:0]    tokens_wanted = '0;
  logic                 refill_to_full = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 granted;
  logic [LEFT_W-1:0]    tokens_left;
  logic [WAIT_W-1:0]    wait_ticks;
  logic                 never_available;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // bucket model
  logic [RATE_W-1:0]  model_rate  = RATE_RST;
  logic [BURST_W-1:0] model_burst = BURST_RST;
  logic [63:0]        bucket_level;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  req_t   req_cur = '0;
  bit     req_busy = 1'b0;
  bit     req_taken = 1'b0;
  bit     req_calm = 1'b0;
  int     req_gap = 0;
  bit     out_calm = 1'b0;
  int     out_hold = 0;
  int     idle_cycles = 0;
  int     mismatches = 0;

  always #2 clk = ~clk;

  token_bucket_limiter_core u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .elapsed_ticks_i   (elapsed_ticks),
    .tokens_wanted_i   (tokens_wanted),
    .refill_to_full_i  (refill_to_full),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .granted_o         (granted),
    .tokens_left_o     (tokens_left),
    .wait_ticks_o      (wait_ticks),
    .never_available_o (never_available),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  function automatic logic [63:0] cap_of(input logic [BURST_W-1:0] burst);
    logic [63:0] whole;
    whole = 64'(burst);
    if (whole > TOKEN_MAX) whole = TOKEN_MAX;
    return whole << FRAC_BITS;
  endfunction

  function automatic void predict_grant(input logic [ELAP_W-1:0] elapsed,
                                        input logic [WANT_W-1:0] want,
                                        input logic to_full);
    logic [63:0] cap;
    logic [63:0] sum;
    logic [63:0] needed;
    grant_t      g;
    cap = cap_of(model_burst);
    g = '0;
    if (to_full) begin
      bucket_level = cap;
    end else begin
      sum = bucket_level + 64'(elapsed) * 64'(model_rate);
      bucket_level = (sum > cap) ? cap : sum;
    end
    needed = 64'(want) << FRAC_BITS;
    if (bucket_level >= needed) begin
      bucket_level = bucket_level - needed;
      g.granted = 1'b1;
    end else if (model_rate == '0) begin
      g.never = 1'b1;
      g.wait_cnt = '1;
    end else begin
      g.wait_cnt = WAIT_W'((needed - bucket_level) / 64'(model_rate));
    end
    g.left = LEFT_W'(bucket_level >> FRAC_BITS);
    expected_grants.push_back(g);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_grant();
    grant_t exp_g;
    if (expected_grants.size() == 0) begin
      report_mismatch($sformatf("unexpected result granted=%0b left=%0d wait=%0d never=%0b",
                                granted, tokens_left, wait_ticks, never_available));
      return;
    end
    exp_g = expected_grants.pop_front();
    if (granted !== exp_g.granted)
      report_mismatch($sformatf("granted %0b, want %0b", granted, exp_g.granted));
    if (tokens_left !== exp_g.left)
      report_mismatch($sformatf("tokens_left %0d, want %0d", tokens_left, exp_g.left));
    if (wait_ticks !== exp_g.wait_cnt)
      report_mismatch($sformatf("wait_ticks %0d, want %0d", wait_ticks, exp_g.wait_cnt));
    if (never_available !== exp_g.never)
      report_mismatch($sformatf("never_available %0b, want %0b", never_available, exp_g.never));
  endtask

  // request driver
  always @(negedge clk) begin
    if (req_taken) req_busy = 1'b0;
    req_taken = 1'b0;
    if (!req_busy && rst_n) begin
      if (req_gap != 0) begin
        req_gap--;
      end else if (pending_reqs.size() != 0) begin
        req_cur = pending_reqs.pop_front();
        req_busy = 1'b1;
        if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
        req_gap = req_calm ? 0 : $urandom_range(0, 10);
      end
    end
    in_valid       <= req_busy;
    elapsed_ticks  <= req_cur.elapsed;
    tokens_wanted  <= req_cur.want;
    refill_to_full <= req_cur.to_full;
    out_stall      <= (out_hold != 0);
  end

  // monitor, prediction and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_grant(elapsed_ticks, tokens_wanted, refill_to_full);
        req_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        check_grant();
        moved = 1'b1;
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 10);
      end else if (out_valid && out_hold != 0) begin
        out_hold--;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FILL_RATE) begin
      model_rate = data[RATE_W-1:0];
    end else if (idx == REG_BURST) begin
      model_burst = data[BURST_W-1:0];
      if (bucket_level > cap_of(model_burst)) bucket_level = cap_of(model_burst);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || req_busy || expected_grants.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_req(input logic [ELAP_W-1:0] elapsed,
                                    input logic [WANT_W-1:0] want, input logic to_full);
    pending_reqs.push_back('{elapsed, want, to_full});
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned top;
    top = (model_burst > 16'd65533) ? 65535 : int'(model_burst) + 2;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: r.elapsed = $urandom_range(0, 3);
      4, 5:       r.elapsed = $urandom_range(0, 64);
      6:          r.elapsed = $urandom_range(0, 65536);
      default:    r.elapsed = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:          r.want = WANT_W'($urandom);
      1, 2, 3:    r.want = WANT_W'($urandom_range(0, top));
      default:    r.want = WANT_W'($urandom_range(0, (top < 4) ? top : 4));
    endcase
    r.to_full = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DAT_W'(1);
      2:       return '1;
      3:       return CFG_DAT_W'(65536);
      4:       return CFG_DAT_W'($urandom_range(1, 4096));
      5:       return CFG_DAT_W'($urandom_range(4096, 1 << 20));
      default: return CFG_DAT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_burst();
    logic [BURST_W-1:0] b;
    case ($urandom_range(0, 7))
      0:       b = '0;
      1:       b = BURST_W'(1);
      2:       b = '1;
      3:       b = BURST_W'(16);
      4, 5:    b = BURST_W'($urandom_range(2, 64));
      default: b = BURST_W'($urandom);
    endcase
    return {(CFG_DAT_W - BURST_W)'($urandom), b};
  endfunction

  initial begin
    bucket_level = cap_of(model_burst);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: one token per tick, burst of 16
    queue_req('0, '0, 1'b0);
    queue_req('0, WANT_W'(16), 1'b0);
    queue_req('0, WANT_W'(1), 1'b0);
    queue_req('1, '1, 1'b0);
    queue_req('0, WANT_W'(5), 1'b1);
    queue_req(ELAP_W'(3), WANT_W'(16), 1'b0);
    settle();

    // zero rate
    write_reg(REG_FILL_RATE, '0);
    queue_req('1, WANT_W'(100), 1'b0);
    queue_req('0, '0, 1'b0);
    queue_req(ELAP_W'(5), WANT_W'(20), 1'b1);
    settle();

    // max rate and burst
    write_reg(REG_FILL_RATE, '1);
    write_reg(REG_BURST, '1);
    queue_req('1, '1, 1'b0);
    queue_req(ELAP_W'(1), '1, 1'b0);
    queue_req('0, '0, 1'b1);
    settle();

    // lowering the burst clamps a full bucket
    write_reg(REG_BURST, CFG_DAT_W'(3));
    queue_req('0, '0, 1'b0);
    queue_req('0, WANT_W'(4), 1'b0);
    settle();

    write_reg(REG_BURST, '0);
    queue_req('0, '0, 1'b0);
    queue_req('1, WANT_W'(1), 1'b0);
    settle();

    write_reg(REG_FILL_RATE, CFG_DAT_W'(1));
    write_reg(REG_BURST, CFG_DAT_W'(16'hFFFF));
    queue_req('0, '1, 1'b0);
    queue_req(ELAP_W'(100), '0, 1'b0);
    settle();

    // unmapped indexes must not touch rate or burst
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    queue_req('0, WANT_W'(1), 1'b1);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_FILL_RATE, rand_rate());
      write_reg(REG_BURST, rand_burst());
      for (int n = 0; n < 150; n++) pending_reqs.push_back(rand_req());
      settle();
    end

    if (expected_grants.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
